// ===== hw/rtl/gtrav_pkg.sv =====
// ----------------------------------------------------------------------------
// Graph traversal package
// Shared sizes, command codes and controller states of the graph traversal
// block.
// ----------------------------------------------------------------------------
package gtrav_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int COUNT_W   = $clog2(MAX_NODES + 1);

    typedef logic [NODE_W-1:0]    node_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [MAX_NODES-1:0] row_t;

    typedef enum logic [1:0] {
        CMD_ADD_EDGE = 2'd0,
        CMD_BFS      = 2'd1,
        CMD_DFS      = 2'd2
    } cmd_t;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_E_RD1   = 12'b0000_0000_0010,
        ST_E_WR1   = 12'b0000_0000_0100,
        ST_E_RD2   = 12'b0000_0000_1000,
        ST_E_WR2   = 12'b0000_0001_0000,
        ST_B_QADDR = 12'b0000_0010_0000,
        ST_B_QDATA = 12'b0000_0100_0000,
        ST_B_SCAN  = 12'b0000_1000_0000,
        ST_D_READ  = 12'b0001_0000_0000,
        ST_D_SCAN  = 12'b0010_0000_0000,
        ST_D_POP   = 12'b0100_0000_0000,
        ST_FLUSH   = 12'b1000_0000_0000
    } state_t;

endpackage

// ===== hw/rtl/graph_bfs_dfs_traversal.sv =====
// ----------------------------------------------------------------------------
// Graph traversal block
// Breadth-first and depth-first search over a bit adjacency matrix kept in
// a synchronous memory, with the queue and the stack sharing a second one.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries one command transaction at a time. An add-edge
// transaction sets one or two adjacency bits and gives no result, with one
// read and one write of the row memory per bit. A traversal transaction
// emits the visited nodes on the m_ channel in visit order, with m_last on
// the final one. Both memories are read synchronously, and the
// breadth-first scan queues one neighbour per cycle. s_ready is high only
// while the controller is idle. When the receiver stalls, the output
// register holds its transaction and the traversal pauses at its next
// visit until the register frees. The cfg_ channel writes node_count and
// is always ready. Reset clears all edges, sets node_count to 16 and
// empties the output.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [3:0] s_from_node,
    input  logic [3:0] s_to_node,
    input  logic       s_directed,
    input  logic [3:0] s_start_node,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_visited_node,
    output logic       m_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data
);

    gtrav_pkg::state_t state_reg, state_next;
    gtrav_pkg::count_t node_count_reg;

    gtrav_pkg::row_t   adj_mem [gtrav_pkg::MAX_NODES];
    gtrav_pkg::row_t   adj_rdata_reg;
    logic              adj_rvalid_reg;
    gtrav_pkg::row_t   row_valid_reg;
    logic              adj_rd_en, adj_wr_en;
    gtrav_pkg::node_t  adj_rd_addr, adj_wr_addr;
    gtrav_pkg::row_t   adj_wr_data;
    gtrav_pkg::row_t   row_eff;

    gtrav_pkg::node_t  wk_mem [gtrav_pkg::MAX_NODES];
    gtrav_pkg::node_t  wk_rdata_reg;
    logic              wk_rd_en, wk_wr_en;
    gtrav_pkg::node_t  wk_rd_addr, wk_wr_addr, wk_wr_data;

    gtrav_pkg::node_t  from_reg, from_next;
    gtrav_pkg::node_t  to_reg, to_next;
    logic              directed_reg, directed_next;
    gtrav_pkg::row_t   marks_reg, marks_next;
    gtrav_pkg::count_t head_reg, head_next;
    gtrav_pkg::count_t tail_reg, tail_next;
    gtrav_pkg::count_t depth_reg, depth_next;
    gtrav_pkg::node_t  top_reg, top_next;

    logic              pend_valid_reg, pend_valid_next;
    gtrav_pkg::node_t  pend_node_reg, pend_node_next;
    logic              m_valid_reg, m_valid_next;
    gtrav_pkg::node_t  m_node_reg, m_node_next;
    logic              m_last_reg, m_last_next;

    gtrav_pkg::count_t n_act;
    gtrav_pkg::row_t   node_mask;
    gtrav_pkg::row_t   cand;
    gtrav_pkg::node_t  low_node;
    logic              emit_req, emit_ok, out_free;
    gtrav_pkg::node_t  emit_node;

    function automatic gtrav_pkg::node_t lowest_set(input gtrav_pkg::row_t v);
        gtrav_pkg::node_t r;
        r = '0;
        for (int i = gtrav_pkg::MAX_NODES - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = gtrav_pkg::NODE_W'(i);
            end
        end
        return r;
    endfunction

    function automatic gtrav_pkg::row_t node_bit(input gtrav_pkg::node_t v);
        return gtrav_pkg::row_t'(1) << v;
    endfunction

    assign s_ready        = (state_reg == gtrav_pkg::ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_visited_node = m_node_reg;
    assign m_last         = m_last_reg;

    assign n_act = (node_count_reg > gtrav_pkg::COUNT_W'(gtrav_pkg::MAX_NODES))
                   ? gtrav_pkg::COUNT_W'(gtrav_pkg::MAX_NODES) : node_count_reg;

    always_comb begin
        for (int i = 0; i < gtrav_pkg::MAX_NODES; i++) begin
            node_mask[i] = (gtrav_pkg::COUNT_W'(i) < n_act);
        end
    end

    assign row_eff  = adj_rvalid_reg ? adj_rdata_reg : '0;
    assign cand     = row_eff & ~marks_reg & node_mask;
    assign low_node = lowest_set(cand);
    assign out_free = !m_valid_reg || m_ready;
    assign emit_ok  = !pend_valid_reg || out_free;

    // Row memory with per-row valid bits that reset clears.
    always_ff @(posedge aclk) begin
        if (adj_wr_en) begin
            adj_mem[adj_wr_addr] <= adj_wr_data;
        end
        if (adj_rd_en) begin
            adj_rdata_reg  <= adj_mem[adj_rd_addr];
            adj_rvalid_reg <= row_valid_reg[adj_rd_addr];
        end
    end

    // Queue and stack memory, shared because one traversal runs at a time.
    always_ff @(posedge aclk) begin
        if (wk_wr_en) begin
            wk_mem[wk_wr_addr] <= wk_wr_data;
        end
        if (wk_rd_en) begin
            wk_rdata_reg <= wk_mem[wk_rd_addr];
        end
    end

    always_comb begin
        state_next      = state_reg;
        from_next       = from_reg;
        to_next         = to_reg;
        directed_next   = directed_reg;
        marks_next      = marks_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        depth_next      = depth_reg;
        top_next        = top_reg;
        pend_valid_next = pend_valid_reg;
        pend_node_next  = pend_node_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_node_next     = m_node_reg;
        m_last_next     = m_last_reg;
        adj_rd_en       = 1'b0;
        adj_rd_addr     = '0;
        adj_wr_en       = 1'b0;
        adj_wr_addr     = '0;
        adj_wr_data     = '0;
        wk_rd_en        = 1'b0;
        wk_rd_addr      = '0;
        wk_wr_en        = 1'b0;
        wk_wr_addr      = '0;
        wk_wr_data      = '0;
        emit_req        = 1'b0;
        emit_node       = '0;

        unique case (state_reg)
            gtrav_pkg::ST_IDLE: begin
                if (s_valid) begin
                    from_next     = s_from_node;
                    to_next       = s_to_node;
                    directed_next = s_directed;
                    unique case (gtrav_pkg::cmd_t'(s_command))
                        gtrav_pkg::CMD_ADD_EDGE: begin
                            if ({1'b0, s_from_node} < n_act && {1'b0, s_to_node} < n_act) begin
                                state_next = gtrav_pkg::ST_E_RD1;
                            end
                        end
                        gtrav_pkg::CMD_BFS: begin
                            if ({1'b0, s_start_node} < n_act) begin
                                marks_next = node_bit(s_start_node);
                                wk_wr_en   = 1'b1;
                                wk_wr_addr = '0;
                                wk_wr_data = s_start_node;
                                head_next  = '0;
                                tail_next  = gtrav_pkg::COUNT_W'(1);
                                state_next = gtrav_pkg::ST_B_QADDR;
                            end
                        end
                        gtrav_pkg::CMD_DFS: begin
                            if ({1'b0, s_start_node} < n_act) begin
                                marks_next = node_bit(s_start_node);
                                emit_req   = 1'b1;
                                emit_node  = s_start_node;
                                top_next   = s_start_node;
                                depth_next = gtrav_pkg::COUNT_W'(1);
                                state_next = gtrav_pkg::ST_D_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            gtrav_pkg::ST_E_RD1: begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = from_reg;
                state_next  = gtrav_pkg::ST_E_WR1;
            end
            gtrav_pkg::ST_E_WR1: begin
                adj_wr_en   = 1'b1;
                adj_wr_addr = from_reg;
                adj_wr_data = row_eff | node_bit(to_reg);
                state_next  = directed_reg ? gtrav_pkg::ST_IDLE : gtrav_pkg::ST_E_RD2;
            end
            gtrav_pkg::ST_E_RD2: begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = to_reg;
                state_next  = gtrav_pkg::ST_E_WR2;
            end
            gtrav_pkg::ST_E_WR2: begin
                adj_wr_en   = 1'b1;
                adj_wr_addr = to_reg;
                adj_wr_data = row_eff | node_bit(from_reg);
                state_next  = gtrav_pkg::ST_IDLE;
            end
            gtrav_pkg::ST_B_QADDR: begin
                if (head_reg == tail_reg) begin
                    state_next = gtrav_pkg::ST_FLUSH;
                end else begin
                    wk_rd_en   = 1'b1;
                    wk_rd_addr = head_reg[gtrav_pkg::NODE_W-1:0];
                    head_next  = head_reg + gtrav_pkg::COUNT_W'(1);
                    state_next = gtrav_pkg::ST_B_QDATA;
                end
            end
            gtrav_pkg::ST_B_QDATA: begin
                emit_req  = 1'b1;
                emit_node = wk_rdata_reg;
                if (emit_ok) begin
                    adj_rd_en   = 1'b1;
                    adj_rd_addr = wk_rdata_reg;
                    state_next  = gtrav_pkg::ST_B_SCAN;
                end
            end
            gtrav_pkg::ST_B_SCAN: begin
                if (cand == '0) begin
                    state_next = gtrav_pkg::ST_B_QADDR;
                end else begin
                    wk_wr_en   = 1'b1;
                    wk_wr_addr = tail_reg[gtrav_pkg::NODE_W-1:0];
                    wk_wr_data = low_node;
                    tail_next  = tail_reg + gtrav_pkg::COUNT_W'(1);
                    marks_next = marks_reg | node_bit(low_node);
                end
            end
            gtrav_pkg::ST_D_READ: begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = top_reg;
                state_next  = gtrav_pkg::ST_D_SCAN;
            end
            gtrav_pkg::ST_D_SCAN: begin
                if (cand != '0) begin
                    emit_req  = 1'b1;
                    emit_node = low_node;
                    if (emit_ok) begin
                        wk_wr_en   = 1'b1;
                        wk_wr_addr = depth_reg[gtrav_pkg::NODE_W-1:0] - gtrav_pkg::NODE_W'(1);
                        wk_wr_data = top_reg;
                        depth_next = depth_reg + gtrav_pkg::COUNT_W'(1);
                        top_next   = low_node;
                        marks_next = marks_reg | node_bit(low_node);
                        state_next = gtrav_pkg::ST_D_READ;
                    end
                end else begin
                    depth_next = depth_reg - gtrav_pkg::COUNT_W'(1);
                    if (depth_reg == gtrav_pkg::COUNT_W'(1)) begin
                        state_next = gtrav_pkg::ST_FLUSH;
                    end else begin
                        wk_rd_en   = 1'b1;
                        wk_rd_addr = depth_reg[gtrav_pkg::NODE_W-1:0] - gtrav_pkg::NODE_W'(2);
                        state_next = gtrav_pkg::ST_D_POP;
                    end
                end
            end
            gtrav_pkg::ST_D_POP: begin
                top_next   = wk_rdata_reg;
                state_next = gtrav_pkg::ST_D_READ;
            end
            gtrav_pkg::ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = gtrav_pkg::ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_node_next     = pend_node_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = gtrav_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gtrav_pkg::ST_IDLE;
            end
        endcase

        // A visited node waits in the pending register until the next visit
        // or the end of the traversal decides its last flag.
        if (emit_req && emit_ok) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_node_next  = pend_node_reg;
                m_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_node_next  = emit_node;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gtrav_pkg::ST_IDLE;
            node_count_reg <= gtrav_pkg::COUNT_W'(gtrav_pkg::MAX_NODES);
            row_valid_reg  <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid) begin
                node_count_reg <= cfg_data;
            end
            if (adj_wr_en) begin
                row_valid_reg[adj_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        from_reg      <= from_next;
        to_reg        <= to_next;
        directed_reg  <= directed_next;
        marks_reg     <= marks_next;
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        depth_reg     <= depth_next;
        top_reg       <= top_next;
        pend_node_reg <= pend_node_next;
        m_node_reg    <= m_node_next;
        m_last_reg    <= m_last_next;
    end

endmodule

// ===== dv/graph_bfs_dfs_traversal_tb.sv =====
// ----------------------------------------------------------------------------
// Graph traversal block testbench
// Drives add-edge, breadth-first and depth-first command transactions into the
// block, predicts the visit order from a local copy of the adjacency matrix
// and the node count, and checks every result transaction in order. Both
// channels idle at random, and the receiver stalls long enough once to fill
// the block.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  CMD_RESERVED  = 2'd3;
    localparam int          RESULT_LIMIT  = 16;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    typedef struct packed {
        gtrav_pkg::node_t node;
        logic             last;
    } visit_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_command;
    logic [3:0] s_from_node;
    logic [3:0] s_to_node;
    logic       s_directed;
    logic [3:0] s_start_node;
    logic       m_valid;
    logic       m_ready;
    logic [3:0] m_visited_node;
    logic       m_last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;

    gtrav_pkg::row_t adj_rows [gtrav_pkg::MAX_NODES];
    logic [4:0]  node_count_reg = 5'd16;
    visit_t      expected_visits [$];
    int          visits_this_item;
    int          error_count = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b1;
    bit          hold_output = 1'b0;

    graph_bfs_dfs_traversal u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_from_node    (s_from_node),
        .s_to_node      (s_to_node),
        .s_directed     (s_directed),
        .s_start_node   (s_start_node),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_visited_node (m_visited_node),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Predictor of the visit order.

    function automatic int unsigned nodes_in_use();
        return (node_count_reg > gtrav_pkg::MAX_NODES) ? gtrav_pkg::MAX_NODES : node_count_reg;
    endfunction

    function automatic void record_visit(gtrav_pkg::node_t node);
        visit_t entry;
        if (visits_this_item < RESULT_LIMIT) begin
            entry.node = node;
            entry.last = 1'b0;
            expected_visits.insert(expected_visits.size(), entry);
            visits_this_item++;
        end
    endfunction

    function automatic void predict_bfs(gtrav_pkg::node_t start, int unsigned n);
        gtrav_pkg::node_t pending [gtrav_pkg::MAX_NODES];
        int unsigned      head;
        int unsigned      tail;
        gtrav_pkg::row_t  marks;
        gtrav_pkg::node_t v;
        head = 0;
        tail = 1;
        pending[0] = start;
        marks = '0;
        marks[start] = 1'b1;
        while (head < tail) begin
            v = pending[head];
            head++;
            record_visit(v);
            for (int unsigned u = 0; u < n; u++) begin
                if (adj_rows[v][u] && !marks[u] && tail < gtrav_pkg::MAX_NODES) begin
                    marks[u] = 1'b1;
                    pending[tail] = gtrav_pkg::node_t'(u);
                    tail++;
                end
            end
        end
    endfunction

    function automatic void predict_dfs(gtrav_pkg::node_t start, int unsigned n);
        gtrav_pkg::node_t frame_node [gtrav_pkg::MAX_NODES];
        int unsigned      frame_next [gtrav_pkg::MAX_NODES];
        int unsigned      depth;
        int unsigned      u;
        gtrav_pkg::node_t v;
        gtrav_pkg::row_t  marks;
        marks = '0;
        marks[start] = 1'b1;
        record_visit(start);
        frame_node[0] = start;
        frame_next[0] = 0;
        depth = 1;
        while (depth > 0) begin
            v = frame_node[depth-1];
            u = frame_next[depth-1];
            while (u < n && !(adj_rows[v][u] && !marks[u]))
                u++;
            if (u < n && depth < gtrav_pkg::MAX_NODES) begin
                frame_next[depth-1] = u + 1;
                marks[u] = 1'b1;
                record_visit(gtrav_pkg::node_t'(u));
                frame_node[depth] = gtrav_pkg::node_t'(u);
                frame_next[depth] = 0;
                depth++;
            end else begin
                depth--;
            end
        end
    endfunction

    function automatic void predict_command(logic [1:0] cmd, gtrav_pkg::node_t from_n,
                                            gtrav_pkg::node_t to_n, logic dir,
                                            gtrav_pkg::node_t start);
        int unsigned n;
        n = nodes_in_use();
        visits_this_item = 0;
        case (cmd)
            gtrav_pkg::CMD_ADD_EDGE: begin
                if (from_n < n && to_n < n) begin
                    adj_rows[from_n][to_n] = 1'b1;
                    if (!dir)
                        adj_rows[to_n][from_n] = 1'b1;
                end
            end
            gtrav_pkg::CMD_BFS: begin
                if (start < n)
                    predict_bfs(start, n);
            end
            gtrav_pkg::CMD_DFS: begin
                if (start < n)
                    predict_dfs(start, n);
            end
            default: begin
            end
        endcase
        if (visits_this_item > 0)
            expected_visits[$].last = 1'b1;
    endfunction

    // Channel drivers.

    task automatic send_command(input logic [1:0] cmd, input gtrav_pkg::node_t from_n,
                                input gtrav_pkg::node_t to_n, input logic dir,
                                input gtrav_pkg::node_t start);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_from_node  <= from_n;
        s_to_node    <= to_n;
        s_directed   <= dir;
        s_start_node <= start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_command(cmd, from_n, to_n, dir, start);
    endtask

    task automatic add_edge(input gtrav_pkg::node_t from_n, input gtrav_pkg::node_t to_n,
                            input logic dir);
        send_command(gtrav_pkg::CMD_ADD_EDGE, from_n, to_n, dir,
                     gtrav_pkg::node_t'($urandom_range(0, 15)));
    endtask

    task automatic traverse(input logic [1:0] cmd, input gtrav_pkg::node_t start);
        send_command(cmd, gtrav_pkg::node_t'($urandom_range(0, 15)),
                     gtrav_pkg::node_t'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)), start);
    endtask

    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (expected_visits.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_node_count(input logic [4:0] value);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        node_count_reg = value;
    endtask

    task automatic send_random_item(input int unsigned n);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (n == 0 || pick >= 97) begin
            send_command(2'($urandom_range(0, 3)), gtrav_pkg::node_t'($urandom_range(0, 15)),
                         gtrav_pkg::node_t'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                         gtrav_pkg::node_t'($urandom_range(0, 15)));
        end else if (pick < 45) begin
            add_edge(gtrav_pkg::node_t'($urandom_range(0, n - 1)),
                     gtrav_pkg::node_t'($urandom_range(0, n - 1)),
                     1'($urandom_range(0, 1)));
        end else if (pick < 85) begin
            traverse($urandom_range(0, 1) ? gtrav_pkg::CMD_BFS : gtrav_pkg::CMD_DFS,
                     gtrav_pkg::node_t'($urandom_range(0, n - 1)));
        end else if (pick < 93) begin
            traverse($urandom_range(0, 1) ? gtrav_pkg::CMD_BFS : gtrav_pkg::CMD_DFS,
                     gtrav_pkg::node_t'($urandom_range(0, 15)));
        end else begin
            add_edge(gtrav_pkg::node_t'($urandom_range(0, 15)),
                     gtrav_pkg::node_t'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)));
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Receiver and result checking.

    initial begin : output_receiver
        int unsigned stall;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_output) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_output = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 17);
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_checker
        visit_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_visits.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction: node %0d last %0b",
                                          m_visited_node, m_last));
            end else begin
                want = expected_visits.pop_front();
                if (m_visited_node !== want.node)
                    report_mismatch($sformatf("visited_node %0d, predicted %0d",
                                              m_visited_node, want.node));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %0b, predicted %0b on node %0d",
                                              m_last, want.last, want.node));
            end
        end
    end

    // Tests.

    task automatic test_edge_and_traversal_basics();
        add_edge(4'd0, 4'd1, 1'b0);
        add_edge(4'd0, 4'd2, 1'b0);
        add_edge(4'd1, 4'd3, 1'b1);
        add_edge(4'd2, 4'd3, 1'b0);
        add_edge(4'd3, 4'd15, 1'b1);
        add_edge(4'd15, 4'd14, 1'b0);
        add_edge(4'd5, 4'd5, 1'b1);
        traverse(gtrav_pkg::CMD_BFS, 4'd0);
        traverse(gtrav_pkg::CMD_DFS, 4'd0);
        traverse(gtrav_pkg::CMD_BFS, 4'd15);
        traverse(gtrav_pkg::CMD_DFS, 4'd9);
        send_command(CMD_RESERVED, 4'd15, 4'd15, 1'b1, 4'd15);
        traverse(gtrav_pkg::CMD_DFS, 4'd5);
    endtask

    task automatic test_range_limits();
        write_node_count(5'd4);
        add_edge(4'd4, 4'd1, 1'b0);
        add_edge(4'd1, 4'd4, 1'b1);
        add_edge(4'd3, 4'd1, 1'b1);
        traverse(gtrav_pkg::CMD_BFS, 4'd7);
        traverse(gtrav_pkg::CMD_DFS, 4'd3);
        traverse(gtrav_pkg::CMD_BFS, 4'd0);
        write_node_count(5'd0);
        add_edge(4'd0, 4'd0, 1'b0);
        traverse(gtrav_pkg::CMD_BFS, 4'd0);
        traverse(gtrav_pkg::CMD_DFS, 4'd0);
    endtask

    task automatic test_count_saturation();
        write_node_count(5'd31);
        traverse(gtrav_pkg::CMD_BFS, 4'd0);
        write_node_count(5'd17);
        traverse(gtrav_pkg::CMD_DFS, 4'd14);
        write_node_count(5'd16);
    endtask

    task automatic test_output_backpressure();
        hold_output = 1'b1;
        repeat (10) traverse($urandom_range(0, 1) ? gtrav_pkg::CMD_BFS : gtrav_pkg::CMD_DFS,
                             4'd0);
        s_valid <= 1'b0;
        while (hold_output) @(posedge aclk);
        wait_until_drained();
    endtask

    task automatic test_random_graphs();
        logic [4:0] phase_counts [10];
        phase_counts = '{5'd16, 5'd8, 5'd16, 5'd3, 5'd1, 5'd12, 5'd16, 5'd2, 5'd16, 5'd16};
        phase_counts[8] = 5'($urandom_range(0, 31));
        foreach (phase_counts[p]) begin
            write_node_count(phase_counts[p]);
            repeat (18) send_random_item(nodes_in_use());
        end
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        write_node_count(5'($urandom_range(9, 16)));
        repeat (30) send_random_item(nodes_in_use());
    endtask

    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_command    <= gtrav_pkg::CMD_ADD_EDGE;
        s_from_node  <= '0;
        s_to_node    <= '0;
        s_directed   <= 1'b0;
        s_start_node <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        foreach (adj_rows[i]) adj_rows[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_edge_and_traversal_basics();
        test_range_limits();
        test_count_saturation();
        test_output_backpressure();
        test_random_graphs();
        test_steady_stream();
        wait_until_drained();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/gtrav_pkg.sv
hw/rtl/graph_bfs_dfs_traversal.sv
dv/graph_bfs_dfs_traversal_tb.sv
